// ===== rtl/spi_pkg.sv =====
// shared types and constants for the slot position interpolator
// no dependencies; used by slot_position_interpolator_unit
package spi_pkg;

  localparam int CoordW    = 24;
  localparam int SlotW     = 10;
  localparam int CfgIdxW   = 2;
  localparam int CfgW      = 23;
  localparam int FrameAlW  = 18;
  localparam int AlphaW    = 17;
  localparam int SnapW     = 23;
  localparam int SnapSqW   = 2 * SnapW;

  localparam logic [AlphaW-1:0] ALPHA_ONE    = 17'd65536;
  localparam logic [SnapW-1:0]  SNAP_RESET   = 23'd76800;
  localparam logic [SnapSqW-1:0] SNAP_SQ_RESET =
    SnapSqW'(64'(SNAP_RESET) * 64'(SNAP_RESET));

  typedef enum logic [CfgIdxW-1:0] {
    REG_INTERP_ENABLE = 2'd0,
    REG_FRAME_ALPHA   = 2'd1,
    REG_SNAP_DISTANCE = 2'd2
  } spi_reg_e;

  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_RENDER = 1'b1
  } spi_func_e;

  typedef struct packed {
    logic                     func;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } spi_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     passed_through;
  } spi_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } spi_vec_t;

endpackage

// ===== rtl/slot_position_interpolator_unit.sv =====
// slot position interpolator: per-slot previous position table and render blend
// depends on spi_pkg (types, register codes, constants)
//
//  channel   dir  handshake               payload
//  in        in   in_valid_i/in_ready_o   in_item_i  (spi_in_t)
//  out       out  out_valid_o/out_ready_i out_item_o (spi_out_t)
//  cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one item per cycle while the output is not stalled; a render item passes stage 1
// (table read), stage 2 (products), stage 3 output register (blend add, snap compare)
// after reset a clearing pass zeroes the table, with in_ready_o low
// a stalled output holds the pipeline; record items write the table and leave
// no item in the pipeline

module slot_position_interpolator_unit #(
  parameter int SLOTS = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  spi_pkg::spi_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output spi_pkg::spi_out_t           out_item_o,
  input  logic                        cfg_we_i,
  input  logic [spi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [spi_pkg::CfgW-1:0]    cfg_wdata_i
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = spi_pkg::CoordW;
  localparam int DW   = CW + 1;
  localparam int SqW  = 2 * CW + 1;
  localparam int PW   = DW + spi_pkg::FrameAlW;
  localparam int BW   = PW - 16;

  // configuration
  logic                          interp_en_q;
  logic [spi_pkg::AlphaW-1:0]    alpha_q;
  logic [spi_pkg::SnapW-1:0]     snap_q;
  logic [spi_pkg::SnapSqW-1:0]   snap_sq_q;
  logic [spi_pkg::AlphaW-1:0]    alpha_d;

  always_comb begin
    if (cfg_wdata_i[spi_pkg::FrameAlW-1]) begin
      alpha_d = '0;
    end else if (cfg_wdata_i[spi_pkg::AlphaW-1:0] > spi_pkg::ALPHA_ONE) begin
      alpha_d = spi_pkg::ALPHA_ONE;
    end else begin
      alpha_d = cfg_wdata_i[spi_pkg::AlphaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_en_q <= 1'b1;
      alpha_q     <= '0;
      snap_q      <= spi_pkg::SNAP_RESET;
      snap_sq_q   <= spi_pkg::SNAP_SQ_RESET;
    end else begin
      snap_sq_q <= spi_pkg::SnapSqW'(snap_q) * spi_pkg::SnapSqW'(snap_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          spi_pkg::REG_INTERP_ENABLE: interp_en_q <= cfg_wdata_i[0];
          spi_pkg::REG_FRAME_ALPHA:   alpha_q     <= alpha_d;
          spi_pkg::REG_SNAP_DISTANCE: snap_q      <= cfg_wdata_i[spi_pkg::SnapW-1:0];
          default: ;
        endcase
      end
    end
  end

  // clearing pass after reset
  logic            clr_active_q;
  logic [IdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IdxW'(SLOTS - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // pipeline flow
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic in_fire;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !clr_active_q;
  assign in_fire    = in_valid_i && in_ready_o;

  logic is_render, in_range;
  logic [IdxW-1:0] slot_idx;

  assign is_render = (in_item_i.func == spi_pkg::FUNC_RENDER);
  assign in_range  = ({1'b0, in_item_i.slot} < (spi_pkg::SlotW + 1)'(SLOTS));
  assign slot_idx  = in_range ? in_item_i.slot[IdxW-1:0] : '0;

  // position table
  spi_pkg::spi_vec_t mem_q [SLOTS];
  spi_pkg::spi_vec_t rd_q;
  spi_pkg::spi_vec_t mem_wdata;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;

  always_comb begin
    mem_wdata = '{x: in_item_i.pos_x, y: in_item_i.pos_y, z: in_item_i.pos_z};
    mem_waddr = slot_idx;
    mem_we    = in_fire && !is_render && in_range;
    if (clr_active_q) begin
      mem_wdata = '0;
      mem_waddr = clr_cnt_q;
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_q <= mem_q[slot_idx];
    end
  end

  // stage 1: current position and blend enable, table data in rd_q
  spi_pkg::spi_vec_t cur1_q;
  logic              ok1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_fire && is_render;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cur1_q <= '{x: in_item_i.pos_x, y: in_item_i.pos_y, z: in_item_i.pos_z};
      ok1_q  <= in_range && interp_en_q;
    end
  end

  logic signed [DW-1:0]  dx, dy, dz;
  logic signed [2*DW-1:0] sqx, sqy;
  logic signed [PW-1:0]  px, py, pz;
  logic signed [spi_pkg::FrameAlW-1:0] alpha_s;

  assign alpha_s = $signed({1'b0, alpha_q});
  assign dx  = {cur1_q.x[CW-1], cur1_q.x} - {rd_q.x[CW-1], rd_q.x};
  assign dy  = {cur1_q.y[CW-1], cur1_q.y} - {rd_q.y[CW-1], rd_q.y};
  assign dz  = {cur1_q.z[CW-1], cur1_q.z} - {rd_q.z[CW-1], rd_q.z};
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign px  = dx * alpha_s;
  assign py  = dy * alpha_s;
  assign pz  = dz * alpha_s;

  // stage 2: registered products
  spi_pkg::spi_vec_t    cur2_q, prev2_q;
  logic [SqW-1:0]       sqx2_q, sqy2_q;
  logic signed [PW-1:0] px2_q, py2_q, pz2_q;
  logic                 ok2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cur2_q  <= cur1_q;
      prev2_q <= rd_q;
      sqx2_q  <= sqx[SqW-1:0];
      sqy2_q  <= sqy[SqW-1:0];
      px2_q   <= px;
      py2_q   <= py;
      pz2_q   <= pz;
      ok2_q   <= ok1_q;
    end
  end

  logic [SqW:0]         d2;
  logic                 snap;
  logic signed [BW-1:0] bx, by, bz;
  spi_pkg::spi_out_t    res_d;

  assign d2   = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign snap = d2 > (SqW + 1)'(snap_sq_q);
  // floor of product >> 16 is the arithmetic shift; result lies between prev and cur
  assign bx   = {{(BW-CW){prev2_q.x[CW-1]}}, prev2_q.x} + px2_q[PW-1:16];
  assign by   = {{(BW-CW){prev2_q.y[CW-1]}}, prev2_q.y} + py2_q[PW-1:16];
  assign bz   = {{(BW-CW){prev2_q.z[CW-1]}}, prev2_q.z} + pz2_q[PW-1:16];

  always_comb begin
    if (!ok2_q || snap) begin
      res_d = '{out_x: cur2_q.x, out_y: cur2_q.y, out_z: cur2_q.z,
                passed_through: 1'b1};
    end else begin
      res_d = '{out_x: bx[CW-1:0], out_y: by[CW-1:0], out_z: bz[CW-1:0],
                passed_through: 1'b0};
    end
  end

  // stage 3: output register
  spi_pkg::spi_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = out_q;

  // checks
  a_record_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_render) |=> !v1_q)
    else $error("record item entered the result pipeline");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_active_q |=> !clr_active_q)
    else $error("clearing pass restarted");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_fire)
    else $error("item accepted during clearing pass");

endmodule
